### rtl/path_to_world_frame_macros.svh
// assertion macros for the path to world frame block
// used by the top level only; expects clk and rst_n in the enclosing scope
`ifndef PATH_TO_WORLD_FRAME_MACROS_SVH
`define PATH_TO_WORLD_FRAME_MACROS_SVH

// same-cycle implication
`define PTW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ptw_pkg.sv
// shared types, constants and tables for the path to world frame block
// no dependencies
package ptw_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int ITER_W       = 5;
    localparam int TRIG_W       = 33;
    localparam int ROT_W        = 34;
    localparam int PHASE_W      = 32;
    localparam int NORM_TOP     = 40;
    localparam int CFG_IDX_W    = 2;
    localparam logic [PHASE_W-1:0] CORDIC_GAIN = 32'd652032874;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X       = 2'd0,
        REG_ORIGIN_Y       = 2'd1,
        REG_ORIGIN_HEADING = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        SRC_HELD0 = 2'd0,
        SRC_HELD1 = 2'd1,
        SRC_NEW   = 2'd2
    } src_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CS,
        ST_CSFIN,
        ST_MUL,
        ST_DRAIN,
        ST_POS,
        ST_ALOAD,
        ST_NORM,
        ST_VEC,
        ST_AFIN,
        ST_EMIT,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic              load_in;
        logic              cs_step;
        logic              cs_fin;
        logic              mul_step;
        logic [2:0]        mul_sel;
        logic              pos_load;
        logic              atan_load;
        logic              norm_step;
        logic              vec_step;
        logic              atan_fin;
        logic [ITER_W-1:0] iter;
        logic              emit_load;
        src_t              emit_src;
        logic              emit_atan;
        logic              emit_end;
        logic              shift;
    } ptw_cmd_t;

    typedef struct packed {
        logic last;
        logic norm_done;
        logic out_full;
    } ptw_sts_t;

    function automatic logic [PHASE_W-1:0] atan_tab(input logic [ITER_W-1:0] i);
        logic [PHASE_W-1:0] r;
        case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/ptw_if.sv
// channel interfaces: path point input, world point output, config writes
// depends on ptw_pkg
interface ptw_in_if #(parameter int COORD_BITS = 32, parameter int ANGLE_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] path_x;
    logic signed [COORD_BITS-1:0] path_y;
    logic signed [ANGLE_BITS-1:0] path_heading;
    logic                         is_last;

    modport source (output valid, path_x, path_y, path_heading, is_last, input ready);
    modport sink (input valid, path_x, path_y, path_heading, is_last, output ready);
endinterface

interface ptw_out_if #(parameter int COORD_BITS = 32, parameter int ANGLE_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] world_x;
    logic signed [COORD_BITS-1:0] world_y;
    logic signed [ANGLE_BITS-1:0] world_heading;
    logic                         path_end;

    modport source (output valid, world_x, world_y, world_heading, path_end, input ready);
    modport sink (input valid, world_x, world_y, world_heading, path_end, output ready);
endinterface

interface ptw_cfg_if #(parameter int DATA_BITS = 32);
    import ptw_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/ptw_ctrl.sv
// sequencer for the path to world frame block: cordic passes, multiply steps,
// result emission and path bookkeeping; depends on ptw_pkg
module ptw_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ptw_pkg::ptw_sts_t  sts,
    output ptw_pkg::ptw_cmd_t  cmd
);
    import ptw_pkg::*;

    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);

    state_t            state_reg, state_next;
    logic [1:0]        seen_reg, seen_next;
    logic [1:0]        k_reg, k_next;
    logic [ITER_W-1:0] iter_reg, iter_next;

    logic [1:0] n_emit;
    src_t       src;

    // result list for the current item
    always_comb
    begin
        n_emit = 2'd0;
        src    = SRC_NEW;
        case (seen_reg)
            2'd0:
            begin
                n_emit = sts.last ? 2'd1 : 2'd0;
                src    = SRC_NEW;
            end
            2'd1:
            begin
                n_emit = sts.last ? 2'd2 : 2'd0;
                src    = (k_reg == 2'd0) ? SRC_HELD1 : SRC_NEW;
            end
            2'd2:
            begin
                n_emit = sts.last ? 2'd3 : 2'd2;
                case (k_reg)
                    2'd0:    src = SRC_HELD0;
                    2'd1:    src = SRC_HELD1;
                    default: src = SRC_NEW;
                endcase
            end
            default:
            begin
                n_emit = sts.last ? 2'd2 : 2'd1;
                src    = (k_reg == 2'd0) ? SRC_HELD1 : SRC_NEW;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seen_reg  <= 2'd0;
            k_reg     <= 2'd0;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            k_reg     <= k_next;
            iter_reg  <= iter_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        seen_next     = seen_reg;
        k_next        = k_reg;
        iter_next     = iter_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.iter      = iter_reg;
        cmd.mul_sel   = iter_reg[2:0];
        cmd.emit_src  = src;
        cmd.emit_atan = seen_reg[1];
        cmd.emit_end  = (src == SRC_NEW);
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    iter_next   = '0;
                    state_next  = ST_CS;
                end
            end
            ST_CS:
            begin
                cmd.cs_step = 1'b1;
                iter_next   = iter_reg + 1'b1;
                if (iter_reg == LAST_ITER)
                begin
                    iter_next  = '0;
                    state_next = ST_CSFIN;
                end
            end
            ST_CSFIN:
            begin
                cmd.cs_fin = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                iter_next    = iter_reg + 1'b1;
                if (iter_reg[2:0] == 3'd7)
                begin
                    iter_next  = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_POS;
            end
            ST_POS:
            begin
                cmd.pos_load = 1'b1;
                k_next       = 2'd0;
                if (seen_reg[1])
                    state_next = ST_ALOAD;
                else if (sts.last)
                    state_next = ST_EMIT;
                else
                    state_next = ST_COMMIT;
            end
            ST_ALOAD:
            begin
                cmd.atan_load = 1'b1;
                state_next    = ST_NORM;
            end
            ST_NORM:
            begin
                if (sts.norm_done)
                begin
                    iter_next  = '0;
                    state_next = ST_VEC;
                end
                else
                    cmd.norm_step = 1'b1;
            end
            ST_VEC:
            begin
                cmd.vec_step = 1'b1;
                iter_next    = iter_reg + 1'b1;
                if (iter_reg == LAST_ITER)
                begin
                    iter_next  = '0;
                    state_next = ST_AFIN;
                end
            end
            ST_AFIN:
            begin
                cmd.atan_fin = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!sts.out_full)
                begin
                    cmd.emit_load = 1'b1;
                    k_next        = k_reg + 1'b1;
                    if (k_reg == n_emit - 2'd1)
                        state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.shift = !sts.last;
                if (sts.last)
                    seen_next = 2'd0;
                else if (seen_reg != 2'd3)
                    seen_next = seen_reg + 2'd1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/ptw_datapath.sv
// datapath: config registers, rotation and vectoring cordics, split
// multiplier with accumulators, held points and output register; uses ptw_pkg
module ptw_datapath #(
    parameter int COORD_BITS = 32,
    parameter int ANGLE_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    ptw_in_if.sink            path_in,
    ptw_out_if.source         world_out,
    ptw_cfg_if.sink           cfg,
    input  ptw_pkg::ptw_cmd_t cmd,
    output ptw_pkg::ptw_sts_t sts
);
    import ptw_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int AB = ANGLE_BITS;
    localparam int OW = (CB - 15 > 17) ? CB - 15 : 17;
    localparam int MW = OW + TRIG_W;
    localparam int AW = CB + TRIG_W + 4;
    localparam int SW = AW - 29;
    localparam int VW = (CB + 1 > 42) ? CB + 4 : 45;
    localparam logic signed [SW-1:0] SAT_HI = {{(SW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-CB+1){1'b1}}, {(CB-1){1'b0}}};
    localparam logic [PHASE_W-1:0] HALF = PHASE_W'(1) << (31 - AB);
    localparam logic [PHASE_W-1:0] HALF_TURN = 32'h8000_0000;

    // configuration
    logic signed [CB-1:0] ox_reg, oy_reg;
    logic [AB-1:0]        oh_reg;

    // captured item
    logic signed [CB-1:0] px_reg, py_reg;
    logic [AB-1:0]        ph_reg;
    logic                 last_reg;

    // rotation cordic and trig results
    logic signed [ROT_W-1:0]  cx_reg, cy_reg, cz_reg;
    logic                     flip_reg;
    logic signed [TRIG_W-1:0] c_reg, s_reg;

    // multiplier and accumulators
    logic signed [MW-1:0] prod_reg;
    logic                 prod_v_reg, prod_hi_reg, prod_y_reg, prod_neg_reg;
    logic signed [AW-1:0] accx_reg, accy_reg;

    // transformed point and held points
    logic signed [CB-1:0] wx_reg, wy_reg;
    logic [AB-1:0]        wh_reg;
    logic signed [CB-1:0] hx_reg [2];
    logic signed [CB-1:0] hy_reg [2];
    logic [AB-1:0]        hh_reg [2];

    // vectoring cordic
    logic signed [VW-1:0] vx_reg, vy_reg;
    logic [PHASE_W-1:0]   az_reg;
    logic                 zero_reg;
    logic [AB-1:0]        ah_reg;

    // output register
    logic                 out_v_reg;
    logic signed [CB-1:0] ox_out_reg, oy_out_reg;
    logic [AB-1:0]        oh_out_reg;
    logic                 end_out_reg;

    logic [PHASE_W-1:0]       phase, phase_rot, zsum;
    logic                     phase_flip;
    logic [PHASE_W-1:0]       atan_i;
    logic signed [OW-1:0]     mul_op;
    logic signed [CB-1:0]     mul_a;
    logic signed [TRIG_W-1:0] mul_p;
    logic signed [AW-1:0]     term;
    logic signed [SW-1:0]     tx, ty;
    logic signed [CB:0]       dx, dy;
    logic signed [VW-1:0]     ay, mag;
    logic signed [CB-1:0]     sel_x, sel_y;
    logic [AB-1:0]            sel_h;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ox_reg <= '0;
            oy_reg <= '0;
            oh_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_ORIGIN_X:       ox_reg <= cfg.data[CB-1:0];
                REG_ORIGIN_Y:       oy_reg <= cfg.data[CB-1:0];
                REG_ORIGIN_HEADING: oh_reg <= cfg.data[AB-1:0];
                default:            ;
            endcase
        end
    end

    assign atan_i     = atan_tab(cmd.iter);
    assign phase      = {oh_reg, {(PHASE_W-AB){1'b0}}};
    // second and third quadrants start from the opposite angle
    assign phase_flip = phase[31] ^ phase[30];
    assign phase_rot  = phase + (phase_flip ? HALF_TURN : '0);

    // mul_sel: bit 2 selects the y sum, bit 1 the path_y operand, bit 0 the upper part
    assign mul_a  = cmd.mul_sel[1] ? py_reg : px_reg;
    assign mul_op = cmd.mul_sel[0] ? OW'(mul_a >>> 16) : $signed(OW'({1'b0, mul_a[15:0]}));
    assign mul_p  = (cmd.mul_sel[2] ^ cmd.mul_sel[1]) ? s_reg : c_reg;
    assign term   = prod_hi_reg ? (AW'(prod_reg) <<< 16) : AW'(prod_reg);

    always_comb
    begin
        tx = SW'(accx_reg >>> 30) + SW'(ox_reg);
        ty = SW'(accy_reg >>> 30) + SW'(oy_reg);
        dx = (CB+1)'(wx_reg) - (CB+1)'(hx_reg[0]);
        dy = (CB+1)'(wy_reg) - (CB+1)'(hy_reg[0]);
        ay = vy_reg[VW-1] ? -vy_reg : vy_reg;
        mag = (vx_reg > ay) ? vx_reg : ay;
        zsum = az_reg + HALF;
    end

    always_comb
    begin
        case (cmd.emit_src)
            SRC_HELD0:
            begin
                sel_x = hx_reg[0];
                sel_y = hy_reg[0];
                sel_h = hh_reg[0];
            end
            SRC_HELD1:
            begin
                sel_x = hx_reg[1];
                sel_y = hy_reg[1];
                sel_h = hh_reg[1];
            end
            default:
            begin
                sel_x = wx_reg;
                sel_y = wy_reg;
                sel_h = wh_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            px_reg   <= path_in.path_x;
            py_reg   <= path_in.path_y;
            ph_reg   <= path_in.path_heading;
            last_reg <= path_in.is_last;
            cx_reg   <= $signed(ROT_W'(CORDIC_GAIN));
            cy_reg   <= '0;
            cz_reg   <= ROT_W'($signed(phase_rot));
            flip_reg <= phase_flip;
            accx_reg <= AW'(536870912);
            accy_reg <= AW'(536870912);
        end
        if (cmd.cs_step)
        begin
            if (!cz_reg[ROT_W-1])
            begin
                cx_reg <= cx_reg - (cy_reg >>> cmd.iter);
                cy_reg <= cy_reg + (cx_reg >>> cmd.iter);
                cz_reg <= cz_reg - $signed(ROT_W'(atan_i));
            end
            else
            begin
                cx_reg <= cx_reg + (cy_reg >>> cmd.iter);
                cy_reg <= cy_reg - (cx_reg >>> cmd.iter);
                cz_reg <= cz_reg + $signed(ROT_W'(atan_i));
            end
        end
        if (cmd.cs_fin)
        begin
            c_reg <= flip_reg ? TRIG_W'(-cx_reg) : TRIG_W'(cx_reg);
            s_reg <= flip_reg ? TRIG_W'(-cy_reg) : TRIG_W'(cy_reg);
        end
        if (cmd.mul_step)
        begin
            prod_reg     <= mul_op * mul_p;
            prod_hi_reg  <= cmd.mul_sel[0];
            prod_y_reg   <= cmd.mul_sel[2];
            prod_neg_reg <= !cmd.mul_sel[2] && cmd.mul_sel[1];
        end
        if (prod_v_reg)
        begin
            if (prod_y_reg)
                accy_reg <= accy_reg + term;
            else if (prod_neg_reg)
                accx_reg <= accx_reg - term;
            else
                accx_reg <= accx_reg + term;
        end
        if (cmd.pos_load)
        begin
            wx_reg <= (tx > SAT_HI) ? CB'(SAT_HI) : ((tx < SAT_LO) ? CB'(SAT_LO) : CB'(tx));
            wy_reg <= (ty > SAT_HI) ? CB'(SAT_HI) : ((ty < SAT_LO) ? CB'(SAT_LO) : CB'(ty));
            wh_reg <= oh_reg + ph_reg;
        end
        if (cmd.atan_load)
        begin
            vx_reg   <= dx[CB] ? -VW'(dx) : VW'(dx);
            vy_reg   <= dx[CB] ? -VW'(dy) : VW'(dy);
            az_reg   <= dx[CB] ? HALF_TURN : '0;
            zero_reg <= (dx == '0) && (dy == '0);
        end
        if (cmd.norm_step)
        begin
            // coarse shift by eight bits while far below the target magnitude
            if (mag[VW-1:32] == '0)
            begin
                vx_reg <= vx_reg <<< 8;
                vy_reg <= vy_reg <<< 8;
            end
            else
            begin
                vx_reg <= vx_reg <<< 1;
                vy_reg <= vy_reg <<< 1;
            end
        end
        if (cmd.vec_step)
        begin
            if (vy_reg[VW-1])
            begin
                vx_reg <= vx_reg - (vy_reg >>> cmd.iter);
                vy_reg <= vy_reg + (vx_reg >>> cmd.iter);
                az_reg <= az_reg - atan_i;
            end
            else
            begin
                vx_reg <= vx_reg + (vy_reg >>> cmd.iter);
                vy_reg <= vy_reg - (vx_reg >>> cmd.iter);
                az_reg <= az_reg + atan_i;
            end
        end
        if (cmd.atan_fin)
            ah_reg <= zero_reg ? '0 : zsum[PHASE_W-1 -: AB];
        if (cmd.shift)
        begin
            hx_reg[0] <= hx_reg[1];
            hy_reg[0] <= hy_reg[1];
            hh_reg[0] <= hh_reg[1];
            hx_reg[1] <= wx_reg;
            hy_reg[1] <= wy_reg;
            hh_reg[1] <= wh_reg;
        end
        if (cmd.emit_load)
        begin
            ox_out_reg  <= sel_x;
            oy_out_reg  <= sel_y;
            oh_out_reg  <= cmd.emit_atan ? ah_reg : sel_h;
            end_out_reg <= cmd.emit_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            prod_v_reg <= cmd.mul_step;
            if (cmd.emit_load)
                out_v_reg <= 1'b1;
            else if (world_out.ready)
                out_v_reg <= 1'b0;
        end
    end

    assign world_out.valid         = out_v_reg;
    assign world_out.world_x       = ox_out_reg;
    assign world_out.world_y       = oy_out_reg;
    assign world_out.world_heading = oh_out_reg;
    assign world_out.path_end      = end_out_reg;

    assign sts.last      = last_reg;
    assign sts.norm_done = zero_reg || (mag[VW-1:NORM_TOP] != '0);
    assign sts.out_full  = out_v_reg;

endmodule

### rtl/path_to_world_frame.sv
// top level of the path to world frame block: controller plus datapath
// depends on ptw_pkg, ptw_if, ptw_ctrl, ptw_datapath and the assertion macros
//
// Converts body-frame path points into world-frame points, one input beat per
// point, one output beat per result. Items are handled one at a time. An item
// without a recomputed heading runs 30 rotation cordic steps to form sin and
// cos of origin_heading, eight partial products on one shared multiplier, then
// rounding and saturation; from the third point of a path on, the vectoring
// cordic also forms atan2 of the neighbour difference once the vector is
// normalized. Results leave through one output register: each result waits
// for the previous beat to leave, and the register holds the final beat while
// the next input is taken. Points leave one item late; the last input of a
// path flushes up to three results. Configuration is taken at any time, one
// write per cycle, and must only change while the block is idle.
`include "path_to_world_frame_macros.svh"

module path_to_world_frame #(
    parameter int COORD_BITS = 32,
    parameter int ANGLE_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    ptw_in_if.sink    path_in,
    ptw_out_if.source world_out,
    ptw_cfg_if.sink   cfg
);
    import ptw_pkg::*;

    ptw_cmd_t cmd;
    ptw_sts_t sts;
    logic     in_ready;

    ptw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (path_in.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ptw_datapath #(
        .COORD_BITS (COORD_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .path_in   (path_in),
        .world_out (world_out),
        .cfg       (cfg),
        .cmd       (cmd),
        .sts       (sts)
    );

    assign path_in.ready = in_ready;

    `PTW_ASSERT_NOW(a_emit_free, cmd.emit_load, !sts.out_full, "result loaded over a waiting beat")
    `PTW_ASSERT_NEXT(a_busy_after_beat, path_in.valid && path_in.ready, !path_in.ready, "input taken twice")
    `PTW_ASSERT_NOW(a_one_unit, 1'b1, $onehot0({cmd.cs_step, cmd.mul_step, cmd.norm_step, cmd.vec_step, cmd.emit_load}), "datapath commands overlap")

endmodule

### test/path_to_world_frame_tb.sv
// testbench for path_to_world_frame: drives path points and config writes,
// predicts world points with a scoreboard class. depends on ptw_pkg and ptw_if
`timescale 1ns / 100ps

module path_to_world_frame_tb;
    import ptw_pkg::*;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] heading;
        bit          path_end;
    } world_pt_t;

    class world_point_board;
        longint      origin_x;
        longint      origin_y;
        logic [15:0] origin_heading;
        longint      held_x[2];
        longint      held_y[2];
        logic [15:0] held_heading[2];
        int unsigned points_seen;
        world_pt_t   expected_q[$];
        int          errors;
        longint      arctan_steps[30] = '{
            536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
            41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
            10, 5, 3, 1};

        function void report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] data);
            case (idx)
                REG_ORIGIN_X:       origin_x = longint'($signed(data));
                REG_ORIGIN_Y:       origin_y = longint'($signed(data));
                REG_ORIGIN_HEADING: origin_heading = data[15:0];
                default: ;
            endcase
        endfunction

        // rotation cordic on the origin heading, q2.30
        function void trig_of(input logic [15:0] ang, output longint c, output longint s);
            logic [31:0] ph;
            bit          flip;
            longint      x, y, z, nx;
            ph = {ang, 16'h0000};
            flip = (ph[31:30] == 2'd1 || ph[31:30] == 2'd2);
            if (flip)
                ph = ph + 32'h8000_0000;
            x = 652032874;
            y = 0;
            z = longint'($signed(ph));
            for (int i = 0; i < 30; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    z -= arctan_steps[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    z += arctan_steps[i];
                end
                x = nx;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function longint rounded_diff(longint a, longint p, longint b, longint q);
            return (a * p - b * q + (longint'(1) <<< 29)) >>> 30;
        endfunction

        function longint clamp_coord(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function logic [15:0] heading_toward(longint dy, longint dx);
            longint      z, nx, m;
            logic [31:0] zu;
            if (dx == 0 && dy == 0)
                return 16'h0000;
            z = 0;
            if (dx < 0)
            begin
                dx = -dx;
                dy = -dy;
                z = 64'sh8000_0000;
            end
            forever
            begin
                m = (dy < 0) ? -dy : dy;
                if (dx > m)
                    m = dx;
                if (m >= (longint'(1) <<< 40))
                    break;
                dx = dx * 2;
                dy = dy * 2;
            end
            for (int i = 0; i < 30; i++)
            begin
                if (dy < 0)
                begin
                    nx = dx - (dy >>> i);
                    dy = dy + (dx >>> i);
                    z -= arctan_steps[i];
                end
                else
                begin
                    nx = dx + (dy >>> i);
                    dy = dy - (dx >>> i);
                    z += arctan_steps[i];
                end
                dx = nx;
            end
            zu = z[31:0] + 32'h0000_8000;
            return zu[31:16];
        endfunction

        function void push(longint x, longint y, logic [15:0] h, bit e);
            world_pt_t p;
            p.x = x[31:0];
            p.y = y[31:0];
            p.heading = h;
            p.path_end = e;
            expected_q.insert(expected_q.size(), p);
        endfunction

        function void hold(longint x, longint y, logic [15:0] h);
            held_x[0] = held_x[1];
            held_y[0] = held_y[1];
            held_heading[0] = held_heading[1];
            held_x[1] = x;
            held_y[1] = y;
            held_heading[1] = h;
        endfunction

        function void note_point(logic [31:0] px, logic [31:0] py, logic [15:0] ph, bit last);
            longint      c, s, ax, ay, wx, wy;
            logic [15:0] wh, h;
            ax = longint'($signed(px));
            ay = longint'($signed(py));
            trig_of(origin_heading, c, s);
            wx = clamp_coord(rounded_diff(ax, c, ay, s) + origin_x);
            wy = clamp_coord(rounded_diff(ax, s, ay, -c) + origin_y);
            wh = origin_heading + ph;
            case (points_seen)
                0:
                begin
                    if (last)
                        push(wx, wy, wh, 1);
                    else
                    begin
                        hold(wx, wy, wh);
                        points_seen = 1;
                    end
                end
                1:
                begin
                    if (last)
                    begin
                        push(held_x[1], held_y[1], held_heading[1], 0);
                        push(wx, wy, wh, 1);
                        points_seen = 0;
                    end
                    else
                    begin
                        hold(wx, wy, wh);
                        points_seen = 2;
                    end
                end
                default:
                begin
                    h = heading_toward(wy - held_y[0], wx - held_x[0]);
                    // first interior point also releases the start point
                    if (points_seen == 2)
                        push(held_x[0], held_y[0], h, 0);
                    push(held_x[1], held_y[1], h, 0);
                    if (last)
                    begin
                        push(wx, wy, h, 1);
                        points_seen = 0;
                    end
                    else
                    begin
                        hold(wx, wy, wh);
                        points_seen = 3;
                    end
                end
            endcase
        endfunction

        function void check_result(logic [31:0] x, logic [31:0] y, logic [15:0] h, bit e);
            world_pt_t p;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected beat x=%h y=%h h=%h end=%b", x, y, h, e));
                return;
            end
            p = expected_q.pop_front();
            if (x !== p.x)
                report($sformatf("world_x %h, want %h", x, p.x));
            if (y !== p.y)
                report($sformatf("world_y %h, want %h", y, p.y));
            if (h !== p.heading)
                report($sformatf("world_heading %h, want %h", h, p.heading));
            if (e !== p.path_end)
                report($sformatf("path_end %b, want %b", e, p.path_end));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ptw_in_if  #(.COORD_BITS(32), .ANGLE_BITS(16)) path_in ();
    ptw_out_if #(.COORD_BITS(32), .ANGLE_BITS(16)) world_out ();
    ptw_cfg_if #(.DATA_BITS(32))                   cfg ();

    path_to_world_frame #(.COORD_BITS(32), .ANGLE_BITS(16)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .path_in   (path_in),
        .world_out (world_out),
        .cfg       (cfg)
    );

    world_point_board board = new();
    bit no_idle = 0;
    bit hold_off_req = 0;

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // beat monitors
    always @(posedge clk)
    begin
        if (rst_n && path_in.valid && path_in.ready)
            board.note_point(path_in.path_x, path_in.path_y, path_in.path_heading,
                             path_in.is_last);
        if (rst_n && world_out.valid && world_out.ready)
            board.check_result(world_out.world_x, world_out.world_y,
                               world_out.world_heading, world_out.path_end);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        int n;
        world_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                world_out.ready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_off_req = 0;
            end
            else
            begin
                world_out.ready <= 1'b1;
                n = $urandom_range(1, 6);
                repeat (n) @(posedge clk);
                n = pick_gap();
                if (n > 0)
                begin
                    world_out.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [15:0] h, bit last);
        int g;
        path_in.valid        <= 1'b1;
        path_in.path_x       <= x;
        path_in.path_y       <= y;
        path_in.path_heading <= h;
        path_in.is_last      <= last;
        do
            @(posedge clk);
        while (!path_in.ready);
        g = pick_gap();
        if (g > 0)
        begin
            path_in.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        path_in.valid <= 1'b0;
        @(posedge clk);
        while (board.expected_q.size() != 0)
            @(posedge clk);
        // a point that yields no beat may still be in flight
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        board.set_reg(idx, data);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_origin(logic [31:0] ox, logic [31:0] oy, logic [15:0] oh);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_HEADING, {16'h0000, oh});
    endtask

    function automatic logic [31:0] rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
        if (r < 85)
            return $urandom;
        if (r < 92)
            return 32'h7FFF_FFFF - $urandom_range(0, 255);
        return 32'h8000_0000 + $urandom_range(0, 255);
    endfunction

    task automatic random_paths(int count);
        int          len;
        int          sent;
        logic [31:0] x, y;
        sent = 0;
        while (sent < count)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 6);
            x = rand_coord();
            y = rand_coord();
            for (int i = 0; i < len; i++)
            begin
                // mostly a smooth walk, sometimes a jump or a repeat
                case ($urandom_range(0, 9))
                    0: begin x = rand_coord(); y = rand_coord(); end
                    1: ;
                    default:
                    begin
                        x = x + 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
                        y = y + 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
                    end
                endcase
                send_point(x, y, 16'($urandom), i == len - 1);
            end
            sent += len;
        end
    endtask

    initial
    begin
        path_in.valid        = 1'b0;
        path_in.path_x       = '0;
        path_in.path_y       = '0;
        path_in.path_heading = '0;
        path_in.is_last      = 1'b0;
        cfg.valid            = 1'b0;
        cfg.index            = REG_ORIGIN_X;
        cfg.data             = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default origin
        send_point(32'h0001_0000, 32'h0002_0000, 16'h7FFF, 1);     // single point
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 0);     // two points
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 1);
        send_point(32'h0000_0000, 32'h0000_0000, 16'h1234, 0);     // three points
        send_point(32'h0003_0000, 32'hFFFD_0000, 16'h4000, 0);
        send_point(32'hFFF0_0000, 32'h0005_0000, 16'hC000, 1);
        send_point(32'h0010_0000, 32'h0010_0000, 16'h0001, 0);     // coincident neighbours
        send_point(32'h0020_0000, 32'h0000_0000, 16'hFFFF, 0);
        send_point(32'h0010_0000, 32'h0010_0000, 16'h0100, 1);
        send_point(32'h0000_0000, 32'h0000_0000, 16'h0000, 0);     // long path
        send_point(32'hFFFF_0000, 32'h0000_8000, 16'h2000, 0);
        send_point(32'hFFFE_0000, 32'h0001_0000, 16'h6000, 0);
        send_point(32'hFFFD_8000, 32'h0002_0000, 16'hA000, 0);
        send_point(32'hFFFC_0000, 32'h0001_8000, 16'hE000, 1);
        drain();

        // extremes push the sums into saturation
        set_origin(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 0);
        send_point(32'h8000_0000, 32'h8000_0000, 16'h8000, 0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 16'h0001, 1);
        drain();
        set_origin(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000);
        send_point(32'h8000_0000, 32'h0000_0000, 16'h7FFF, 0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 1);
        random_paths(100);
        drain();

        set_origin($urandom, $urandom, 16'($urandom));
        hold_off_req = 1;
        random_paths(120);
        drain();

        set_origin(32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000,
                   32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000, 16'h4000);
        no_idle = 1;
        random_paths(60);
        no_idle = 0;
        random_paths(60);
        drain();

        set_origin(32'h0000_0000, 32'h0000_0000, 16'($urandom));
        random_paths(100);
        drain();

        if (board.expected_q.size() != 0)
            board.report("results still outstanding at end");
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl
rtl/ptw_pkg.sv
rtl/ptw_if.sv
rtl/ptw_ctrl.sv
rtl/ptw_datapath.sv
rtl/path_to_world_frame.sv
test/path_to_world_frame_tb.sv
